>>> hdl/first_fit_arena_allocator_defines.svh
// Assertion macros for the first-fit arena allocator.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFAA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFAA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffaa_pkg.sv
// Shared constants and types for the first-fit arena allocator.
// Used by the top level; no dependencies.
package ffaa_pkg;

  localparam int unsigned ARENA_BYTES     = 65536;
  localparam int unsigned ALIGN_BYTES     = 8;
  localparam int unsigned HDR_BYTES       = 24;
  localparam int unsigned MIN_SPLIT_BYTES = 16;

  localparam int unsigned ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int unsigned GRANULES    = ARENA_BYTES / ALIGN_BYTES;
  localparam int unsigned HDR_G       = (HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  // Smallest leftover, in granules, that is worth splitting off as a free tail.
  localparam int unsigned SPLIT_MIN_G =
    (HDR_G * ALIGN_BYTES + MIN_SPLIT_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned GW = $clog2(GRANULES);
  localparam int unsigned NW = GW + 1;
  localparam int unsigned CAPACITY = (GRANULES - HDR_G) * ALIGN_BYTES;

  // Field widths of the stream payloads.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned LIVE_W   = 12;
  localparam int unsigned IN_W     = 56;
  localparam int unsigned OUT_W    = 80;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_RESIZE = 3'd2,
    KIND_RESET  = 3'd3,
    KIND_CHECK  = 3'd4
  } kind_e;

  // One entry of the block metadata memory, indexed by header granule.
  typedef struct packed {
    logic          begins;
    logic          used;
    logic [GW-1:0] size;
  } meta_t;

  localparam int unsigned META_W = $bits(meta_t);

endpackage

>>> hdl/ffaa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffaa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/first_fit_arena_allocator.sv
// First-fit arena allocator: keeps the block chain of one arena in two RAMs
// (block metadata, previous-block links) and works each request with a small
// sequencer around a set of next-block adders and compares. An alloc walks
// the chain from granule zero block by block, then splits the found block
// and updates the counters. A free checks the block, merges it with a free
// next block and then with a free previous block. A resize works in place,
// or does a full alloc scan plus a free when it has to move. After the reset
// input is released, and after every reset request, the block sweeps all
// GRANULES (8192) entries of the metadata RAM, one entry a cycle, while
// s_axis_tready stays low. Only one request is worked at a time; the next
// request is taken while a finished result still waits on the master side.
// Depends on ffaa_pkg, ffaa_ram and first_fit_arena_allocator_defines.svh.
`include "first_fit_arena_allocator_defines.svh"

module first_fit_arena_allocator
  import ffaa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: request_bytes[31:0], payload_offset[47:32], pointer_present[48], zero fill
  input  logic [IN_W-1:0]   s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [KIND_W-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: result_offset[15:0], granted[16], bytes_in_use[32:17], bytes_peak[48:33],
  // blocks_live[60:49], capacity[76:61], flag_out_of_memory[77], flag_corrupt[78],
  // flag_leak[79]
  output logic [OUT_W-1:0]  m_axis_tdata
);

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_CLEAR    = 22'h000002,
    ST_SCAN     = 22'h000004,
    ST_ALC_FIN  = 22'h000008,
    ST_SPL_GO   = 22'h000010,
    ST_SPL_S    = 22'h000020,
    ST_MRG_GO   = 22'h000040,
    ST_MRG_CHK  = 22'h000080,
    ST_MRG_WM   = 22'h000100,
    ST_FREE_GO  = 22'h000200,
    ST_FREE_CHK = 22'h000400,
    ST_FREE_PRV = 22'h000800,
    ST_PREV_RD  = 22'h001000,
    ST_PREV_CHK = 22'h002000,
    ST_RSZ_CHK  = 22'h004000,
    ST_RSZ_SHR  = 22'h008000,
    ST_RSZ_SHN  = 22'h010000,
    ST_RSZ_GRN  = 22'h020000,
    ST_RSZ_GSP  = 22'h040000,
    ST_RSZ_GFN  = 22'h080000,
    ST_ALC_GO   = 22'h100000,
    ST_FIN      = 22'h200000
  } state_e;

  localparam logic [NW-1:0] HDR_N  = NW'(HDR_G);
  localparam logic [NW-1:0] GRAN_N = NW'(GRANULES);

  state_e state_q, state_d, ret_q, ret_d;

  logic [GW-1:0]      clr_q, clr_d;
  logic               clr_boot_q, clr_boot_d;
  logic [GW-1:0]      cur_q, cur_d;
  logic [GW-1:0]      csz_q, csz_d;
  logic               cuse_q, cuse_d;
  logic [GW-1:0]      s_q, s_d;
  logic [GW-1:0]      old_q, old_d;
  logic [GW-1:0]      n_q, n_d;
  logic [NW-1:0]      wg_q, wg_d;
  logic               fb_q, fb_d;
  logic [OFF_W-1:0]   offset_q, offset_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               ok_q, ok_d;
  logic [BYTES_W-1:0] used_q, used_d;
  logic [BYTES_W-1:0] peak_q, peak_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic               oom_q, oom_d;
  logic               cor_q, cor_d;
  logic               leak_q, leak_d;
  logic               m_valid_q, m_valid_d;
  logic [OUT_W-1:0]   m_data_q, m_data_d;

  // Memory ports.
  logic          meta_we;
  logic [GW-1:0] meta_waddr;
  meta_t         meta_wdata;
  logic [GW-1:0] meta_raddr;
  meta_t         meta_rd;
  logic          prev_we;
  logic [GW-1:0] prev_waddr;
  logic [GW-1:0] prev_wdata;
  logic [GW-1:0] prev_raddr;
  logic [GW-1:0] prev_rd;

  ffaa_ram #(.WIDTH(META_W), .DEPTH(GRANULES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rd)
  );

  ffaa_ram #(.WIDTH(GW), .DEPTH(GRANULES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rd)
  );

  // Request fields.
  logic                   in_acc;
  kind_e                  in_kind;
  logic [REQ_W-1:0]       in_req;
  logic [OFF_W-1:0]       in_off;
  logic                   in_present;
  logic [REQ_W-1:0]       req_n;
  logic [REQ_W-ALIGN_SHIFT:0] wg_full;
  logic [NW-1:0]          wg_in;
  logic [OFF_W-1:0]       loc_g;
  logic                   loc_ok;
  logic [GW-1:0]          loc_s;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_kind       = kind_e'(s_axis_tuser);
  assign in_req        = s_axis_tdata[REQ_W-1:0];
  assign in_off        = s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
  assign in_present    = s_axis_tdata[REQ_W+OFF_W];

  // Request size in granules, saturated to the next-block adder width.
  assign req_n   = (in_req == '0) ? REQ_W'(1) : in_req;
  assign wg_full = {1'b0, req_n[REQ_W-1:ALIGN_SHIFT]}
                 + (REQ_W-ALIGN_SHIFT+1)'(|req_n[ALIGN_SHIFT-1:0]);
  assign wg_in   = (|wg_full[REQ_W-ALIGN_SHIFT:NW]) ? '1 : wg_full[NW-1:0];

  // Offset to header granule lookup.
  assign loc_g  = in_off >> ALIGN_SHIFT;
  assign loc_ok = (in_off[ALIGN_SHIFT-1:0] == '0) && (32'(loc_g) >= HDR_G)
               && (32'(loc_g) - HDR_G < GRANULES);
  assign loc_s  = GW'(32'(loc_g) - HDR_G);

  // Shared next-block adders.
  logic [NW-1:0]   rd_end, cur_end, s_end_rd, s_end_c, spl_t;
  logic [NW:0]     grow_sum;
  logic [GW-1:0]   rem;
  logic [BYTES_W-1:0] rd_bytes;

  assign rd_end   = {1'b0, cur_q} + HDR_N + {1'b0, meta_rd.size};
  assign cur_end  = {1'b0, cur_q} + HDR_N + {1'b0, csz_q};
  assign s_end_rd = {1'b0, s_q} + HDR_N + {1'b0, meta_rd.size};
  assign s_end_c  = {1'b0, s_q} + HDR_N + {1'b0, csz_q};
  assign spl_t    = {1'b0, cur_q} + HDR_N + wg_q;
  assign grow_sum = {2'b0, old_q} + {1'b0, HDR_N} + {2'b0, meta_rd.size};
  assign rem      = csz_q - wg_q[GW-1:0];
  assign rd_bytes = BYTES_W'(meta_rd.size) << ALIGN_SHIFT;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    clr_d      = clr_q;
    clr_boot_d = clr_boot_q;
    cur_d      = cur_q;
    csz_d      = csz_q;
    cuse_d     = cuse_q;
    s_d        = s_q;
    old_d      = old_q;
    n_d        = n_q;
    wg_d       = wg_q;
    fb_d       = fb_q;
    offset_d   = offset_q;
    off_d      = off_q;
    ok_d       = ok_q;
    used_d     = used_q;
    peak_d     = (used_q > peak_q) ? used_q : peak_q;
    live_d     = live_q;
    oom_d      = oom_q;
    cor_d      = cor_q;
    leak_d     = leak_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    meta_we    = 1'b0;
    meta_waddr = cur_q;
    meta_wdata = '0;
    meta_raddr = cur_q;
    prev_we    = 1'b0;
    prev_waddr = cur_q;
    prev_wdata = cur_q;
    prev_raddr = s_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ok_d     = 1'b0;
          off_d    = '0;
          fb_d     = 1'b0;
          wg_d     = wg_in;
          offset_d = in_off;
          s_d      = loc_s;
          case (in_kind)
            KIND_ALLOC: begin
              cur_d      = '0;
              meta_raddr = '0;
              state_d    = ST_SCAN;
            end
            KIND_FREE: begin
              if (!in_present) begin
                state_d = ST_FIN;
              end else if (!loc_ok) begin
                cor_d   = 1'b1;
                state_d = ST_FIN;
              end else begin
                meta_raddr = loc_s;
                state_d    = ST_FREE_CHK;
              end
            end
            KIND_RESIZE: begin
              if (!in_present) begin
                cur_d      = '0;
                meta_raddr = '0;
                state_d    = ST_SCAN;
              end else if (!loc_ok) begin
                cor_d   = 1'b1;
                state_d = ST_FIN;
              end else begin
                meta_raddr = loc_s;
                state_d    = (in_req == '0) ? ST_FREE_CHK : ST_RSZ_CHK;
              end
            end
            KIND_RESET: begin
              used_d     = '0;
              peak_d     = '0;
              live_d     = '0;
              oom_d      = 1'b0;
              cor_d      = 1'b0;
              leak_d     = 1'b0;
              clr_d      = '0;
              clr_boot_d = 1'b0;
              state_d    = ST_CLEAR;
            end
            KIND_CHECK: begin
              if (live_q != '0 || used_q != '0) begin
                leak_d = 1'b1;
              end
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      // Sweep the metadata: one free block at granule zero spans the arena.
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        if (clr_q == '0) begin
          meta_wdata = '{begins: 1'b1, used: 1'b0, size: GW'(GRANULES - HDR_G)};
        end
        clr_d = clr_q + GW'(1);
        if (clr_q == GW'(GRANULES - 1)) begin
          state_d = clr_boot_q ? ST_IDLE : ST_FIN;
        end
      end

      // Fallback alloc for a resize that cannot stay in place.
      ST_ALC_GO: begin
        fb_d       = 1'b1;
        cur_d      = '0;
        meta_raddr = '0;
        state_d    = ST_SCAN;
      end

      // First-fit walk, one block per cycle.
      ST_SCAN: begin
        if (!meta_rd.used && {1'b0, meta_rd.size} >= wg_q) begin
          csz_d   = meta_rd.size;
          ret_d   = ST_ALC_FIN;
          state_d = ST_SPL_GO;
        end else if (rd_end >= GRAN_N) begin
          oom_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          cur_d      = rd_end[GW-1:0];
          meta_raddr = rd_end[GW-1:0];
        end
      end

      ST_ALC_FIN: begin
        used_d = used_q + (BYTES_W'(csz_q) << ALIGN_SHIFT);
        live_d = live_q + LIVE_W'(1);
        off_d  = OFF_W'((32'(cur_q) + HDR_G) << ALIGN_SHIFT);
        ok_d   = 1'b1;
        state_d = fb_q ? ST_FREE_GO : ST_FIN;
      end

      // Split cur: first write the free tail, then shrink cur; a small leftover stays in cur.
      ST_SPL_GO: begin
        meta_we = 1'b1;
        if (32'(rem) >= SPLIT_MIN_G) begin
          meta_waddr = spl_t[GW-1:0];
          meta_wdata = '{begins: 1'b1, used: 1'b0, size: rem - GW'(HDR_G)};
          prev_we    = 1'b1;
          prev_waddr = spl_t[GW-1:0];
          prev_wdata = cur_q;
          n_d        = spl_t[GW-1:0];
          state_d    = ST_SPL_S;
        end else begin
          meta_waddr = cur_q;
          meta_wdata = '{begins: 1'b1, used: 1'b1, size: csz_q};
          state_d    = ret_q;
        end
      end

      ST_SPL_S: begin
        meta_we    = 1'b1;
        meta_waddr = cur_q;
        meta_wdata = '{begins: 1'b1, used: 1'b1, size: wg_q[GW-1:0]};
        if (cur_end < GRAN_N) begin
          prev_we    = 1'b1;
          prev_waddr = cur_end[GW-1:0];
          prev_wdata = n_q;
        end
        csz_d   = wg_q[GW-1:0];
        state_d = ret_q;
      end

      // Merge cur with its successor when that one is free.
      ST_MRG_GO: begin
        if (cur_end >= GRAN_N) begin
          state_d = ret_q;
        end else begin
          meta_raddr = cur_end[GW-1:0];
          n_d        = cur_end[GW-1:0];
          state_d    = ST_MRG_CHK;
        end
      end

      ST_MRG_CHK: begin
        if (meta_rd.used) begin
          state_d = ret_q;
        end else begin
          csz_d      = csz_q + GW'(HDR_G) + meta_rd.size;
          meta_we    = 1'b1;
          meta_waddr = n_q;
          meta_wdata = '0;
          state_d    = ST_MRG_WM;
        end
      end

      ST_MRG_WM: begin
        meta_we    = 1'b1;
        meta_waddr = cur_q;
        meta_wdata = '{begins: 1'b1, used: cuse_q, size: csz_q};
        if (cur_end < GRAN_N) begin
          prev_we    = 1'b1;
          prev_waddr = cur_end[GW-1:0];
          prev_wdata = cur_q;
        end
        state_d = ret_q;
      end

      // Free of the old block after a moving resize.
      ST_FREE_GO: begin
        meta_raddr = s_q;
        state_d    = ST_FREE_CHK;
      end

      ST_FREE_CHK: begin
        if (!meta_rd.begins || !meta_rd.used || used_q < rd_bytes || live_q == '0) begin
          cor_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          used_d     = used_q - rd_bytes;
          live_d     = live_q - LIVE_W'(1);
          meta_we    = 1'b1;
          meta_waddr = s_q;
          meta_wdata = '{begins: 1'b1, used: 1'b0, size: meta_rd.size};
          cur_d      = s_q;
          csz_d      = meta_rd.size;
          cuse_d     = 1'b0;
          ret_d      = ST_FREE_PRV;
          state_d    = ST_MRG_GO;
        end
      end

      // Coalesce with a free predecessor.
      ST_FREE_PRV: begin
        if (s_q == '0) begin
          state_d = ST_FIN;
        end else begin
          prev_raddr = s_q;
          state_d    = ST_PREV_RD;
        end
      end

      ST_PREV_RD: begin
        cur_d      = prev_rd;
        meta_raddr = prev_rd;
        state_d    = ST_PREV_CHK;
      end

      ST_PREV_CHK: begin
        if (meta_rd.used) begin
          state_d = ST_FIN;
        end else begin
          csz_d   = meta_rd.size;
          cuse_d  = 1'b0;
          ret_d   = ST_FIN;
          state_d = ST_MRG_GO;
        end
      end

      // Resize: shrink in place, grow into the successor, or move.
      ST_RSZ_CHK: begin
        if (!meta_rd.begins || !meta_rd.used) begin
          cor_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          old_d = meta_rd.size;
          if (wg_q <= {1'b0, meta_rd.size}) begin
            cur_d   = s_q;
            csz_d   = meta_rd.size;
            ret_d   = ST_RSZ_SHR;
            state_d = ST_SPL_GO;
          end else if (s_end_rd < GRAN_N) begin
            meta_raddr = s_end_rd[GW-1:0];
            state_d    = ST_RSZ_GRN;
          end else begin
            state_d = ST_ALC_GO;
          end
        end
      end

      ST_RSZ_SHR: begin
        used_d = used_q - (BYTES_W'(old_q - csz_q) << ALIGN_SHIFT);
        ok_d   = 1'b1;
        off_d  = offset_q;
        if (s_end_c < GRAN_N) begin
          cur_d      = s_end_c[GW-1:0];
          meta_raddr = s_end_c[GW-1:0];
          state_d    = ST_RSZ_SHN;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_RSZ_SHN: begin
        if (meta_rd.used) begin
          state_d = ST_FIN;
        end else begin
          csz_d   = meta_rd.size;
          cuse_d  = 1'b0;
          ret_d   = ST_FIN;
          state_d = ST_MRG_GO;
        end
      end

      ST_RSZ_GRN: begin
        if (!meta_rd.used && grow_sum >= {1'b0, wg_q}) begin
          cur_d   = s_q;
          csz_d   = old_q;
          cuse_d  = 1'b1;
          ret_d   = ST_RSZ_GSP;
          state_d = ST_MRG_GO;
        end else begin
          state_d = ST_ALC_GO;
        end
      end

      ST_RSZ_GSP: begin
        ret_d   = ST_RSZ_GFN;
        state_d = ST_SPL_GO;
      end

      ST_RSZ_GFN: begin
        used_d  = used_q + (BYTES_W'(csz_q - old_q) << ALIGN_SHIFT);
        ok_d    = 1'b1;
        off_d   = offset_q;
        state_d = ST_FIN;
      end

      // Load the result register once it is free.
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {leak_q, cor_q, oom_q, OFF_W'(CAPACITY), live_q,
                       (used_q > peak_q) ? used_q : peak_q, used_q,
                       ok_q, ok_q ? off_q : OFF_W'(0)};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ret_q      <= ST_FIN;
      clr_q      <= '0;
      clr_boot_q <= 1'b1;
      fb_q       <= 1'b0;
      ok_q       <= 1'b0;
      used_q     <= '0;
      peak_q     <= '0;
      live_q     <= '0;
      oom_q      <= 1'b0;
      cor_q      <= 1'b0;
      leak_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      clr_q      <= clr_d;
      clr_boot_q <= clr_boot_d;
      fb_q       <= fb_d;
      ok_q       <= ok_d;
      used_q     <= used_d;
      peak_q     <= peak_d;
      live_q     <= live_d;
      oom_q      <= oom_d;
      cor_q      <= cor_d;
      leak_q     <= leak_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    csz_q    <= csz_d;
    cuse_q   <= cuse_d;
    s_q      <= s_d;
    old_q    <= old_d;
    n_q      <= n_d;
    wg_q     <= wg_d;
    offset_q <= offset_d;
    off_q    <= off_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Checks on the sequencer and the result register.
  `FFAA_ASSERT_IMP(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready,
                   "request accepted during the metadata sweep")
  `FFAA_ASSERT_IMP(a_null_offset_zero, m_valid_q && !m_data_q[16], m_data_q[15:0] == '0,
                   "null result carries a nonzero offset")
  `FFAA_ASSERT_IMP(a_peak_covers_use, m_valid_q, m_data_q[48:33] >= m_data_q[32:17],
                   "reported peak below bytes in use")
  `FFAA_ASSERT_NXT(a_fin_loads_result, state_q == ST_FIN && (!m_valid_q || m_axis_tready),
                   m_valid_q, "finished request did not present a result")

endmodule
